### design/page_frame_buffer_i2c_refresh_core_macros.svh
// Assertion macros shared by the design files.
// PFB_ASSERT checks a same-cycle property, PFB_ASSERT_NEXT an implication
// into the following cycle. Both sample on clk and are disabled in reset.
`ifndef PAGE_FRAME_BUFFER_I2C_REFRESH_CORE_MACROS_SVH
`define PAGE_FRAME_BUFFER_I2C_REFRESH_CORE_MACROS_SVH

`ifndef SYNTH

`define PFB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfb assertion failed");

`define PFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfb assertion failed");

`else

`define PFB_ASSERT(label, prop)

`define PFB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/pfb_pkg.sv
`default_nettype none

package pfb_pkg;

  localparam int COLUMNS_DEFAULT = 128;
  localparam int PAGES_DEFAULT   = 8;

  // input opcodes; codes 5 to 7 are unused
  localparam logic [2:0] OP_SET_PIXEL   = 3'd0;
  localparam logic [2:0] OP_CLEAR_PIXEL = 3'd1;
  localparam logic [2:0] OP_CLEAR_STORE = 3'd2;
  localparam logic [2:0] OP_REFRESH     = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_COMMAND   = 8'h00;
  localparam logic [7:0] CTRL_DATA      = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW    = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
  localparam logic [2:0] BIT_MSB        = 3'd7;

  typedef struct packed {
    logic start;
    logic tick;
  } seq_ctrl_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
  } seq_pins_t;

endpackage

`default_nettype wire

### design/pfb_seq.sv
`default_nettype none
`include "page_frame_buffer_i2c_refresh_core_macros.svh"

module pfb_seq #(
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = pfb_pkg::PAGES_DEFAULT,
  parameter int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1,
  parameter int COL_W   = $clog2(COLUMNS)
) (
  input  logic               clk,
  input  logic               rst,
  input  pfb_pkg::seq_ctrl_t ctrl,
  input  logic [7:0]         store_byte,
  input  logic [7:0]         dev_addr,
  output logic               busy,
  output logic [PAGE_W-1:0]  rd_page,
  output logic [COL_W-1:0]   rd_col,
  output pfb_pkg::seq_pins_t pins_next
);
  import pfb_pkg::*;

  typedef enum logic [2:0] {PH_IDLE, PH_CMD0, PH_CMD1, PH_CMD2, PH_DATA} phase_t;
  typedef enum logic [1:0] {SEG_START, SEG_BYTE, SEG_ACK, SEG_STOP} seg_t;
  typedef enum logic [1:0] {STG_ADDR, STG_CTRL, STG_PAYLOAD} stage_t;

  phase_t            phase, phase_next;
  seg_t              seg, seg_next;
  stage_t            stage, stage_next;
  logic [PAGE_W-1:0] page, page_next;
  logic [COL_W-1:0]  byte_cnt, byte_cnt_next;
  logic [2:0]        bit_cnt, bit_cnt_next;
  logic [1:0]        step, step_next;
  logic [7:0]        shift, shift_next;
  logic              scl, scl_next;
  logic              sda, sda_next;

  logic              load;
  logic [7:0]        load_val;
  logic              begin_tx;
  logic [7:0]        cmd_byte;
  logic              more_bytes;
  logic              last_page;

  assign busy    = (phase != PH_IDLE);
  assign rd_page = page;
  assign rd_col  = (stage == STG_CTRL) ? '0 : COL_W'(32'(byte_cnt) + 1);

  assign more_bytes = (32'(byte_cnt) + 1) < COLUMNS;
  assign last_page  = (32'(page) + 1) >= PAGES;

  always_comb begin
    cmd_byte = CMD_COL_HIGH;
    if (phase == PH_CMD0) begin
      cmd_byte = 8'(CMD_PAGE_BASE + 8'(page));
    end else if (phase == PH_CMD1) begin
      cmd_byte = CMD_COL_LOW;
    end
  end

  always_comb begin
    phase_next    = phase;
    seg_next      = seg;
    stage_next    = stage;
    page_next     = page;
    byte_cnt_next = byte_cnt;
    bit_cnt_next  = bit_cnt;
    step_next     = step;
    shift_next    = shift;
    scl_next      = scl;
    sda_next      = sda;
    load          = 1'b0;
    load_val      = dev_addr;
    begin_tx      = 1'b0;

    if (ctrl.start) begin
      page_next  = '0;
      phase_next = PH_CMD0;
      begin_tx   = 1'b1;
    end else if (ctrl.tick && busy) begin
      case (seg)
        SEG_START: begin
          case (step)
            2'd0:    sda_next = 1'b1;
            2'd1:    scl_next = 1'b1;
            2'd2:    sda_next = 1'b0;
            default: scl_next = 1'b0;
          endcase
          if (step == 2'd3) begin
            load     = 1'b1;
            load_val = dev_addr;
          end else begin
            step_next = step + 2'd1;
          end
        end
        SEG_BYTE: begin
          case (step)
            2'd0:    scl_next = 1'b0;
            2'd1:    sda_next = shift[bit_cnt];
            2'd2:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
          if (step == 2'd3) begin
            step_next = '0;
            if (bit_cnt == '0) begin
              seg_next = SEG_ACK;
            end else begin
              bit_cnt_next = bit_cnt - 3'd1;
            end
          end else begin
            step_next = step + 2'd1;
          end
        end
        SEG_ACK: begin
          if (step == 2'd0) begin
            scl_next  = 1'b1;
            step_next = 2'd1;
          end else begin
            scl_next = 1'b0;
            case (stage)
              STG_ADDR: begin
                stage_next = STG_CTRL;
                load       = 1'b1;
                load_val   = (phase == PH_DATA) ? CTRL_DATA : CTRL_COMMAND;
              end
              STG_CTRL: begin
                stage_next    = STG_PAYLOAD;
                byte_cnt_next = '0;
                load          = 1'b1;
                load_val      = (phase == PH_DATA) ? store_byte : cmd_byte;
              end
              default: begin
                if (phase == PH_DATA && more_bytes) begin
                  byte_cnt_next = COL_W'(32'(byte_cnt) + 1);
                  load          = 1'b1;
                  load_val      = store_byte;
                end else begin
                  seg_next  = SEG_STOP;
                  step_next = '0;
                end
              end
            endcase
          end
        end
        default: begin
          case (step)
            2'd0:    scl_next = 1'b1;
            2'd1:    sda_next = 1'b0;
            default: sda_next = 1'b1;
          endcase
          if (step >= 2'd2) begin
            case (phase)
              PH_DATA: begin
                if (last_page) begin
                  page_next  = '0;
                  phase_next = PH_IDLE;
                end else begin
                  page_next  = PAGE_W'(32'(page) + 1);
                  phase_next = PH_CMD0;
                  begin_tx   = 1'b1;
                end
              end
              PH_CMD0: begin
                phase_next = PH_CMD1;
                begin_tx   = 1'b1;
              end
              PH_CMD1: begin
                phase_next = PH_CMD2;
                begin_tx   = 1'b1;
              end
              default: begin
                phase_next = PH_DATA;
                begin_tx   = 1'b1;
              end
            endcase
          end else begin
            step_next = step + 2'd1;
          end
        end
      endcase
    end

    if (load) begin
      shift_next   = load_val;
      bit_cnt_next = BIT_MSB;
      step_next    = '0;
      seg_next     = SEG_BYTE;
    end
    if (begin_tx) begin
      seg_next      = SEG_START;
      step_next     = '0;
      stage_next    = STG_ADDR;
      byte_cnt_next = '0;
    end
  end

  assign pins_next.scl  = scl_next;
  assign pins_next.sda  = sda_next;
  assign pins_next.busy = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      seg      <= SEG_START;
      stage    <= STG_ADDR;
      page     <= '0;
      byte_cnt <= '0;
      bit_cnt  <= BIT_MSB;
      step     <= '0;
      shift    <= '0;
      scl      <= 1'b1;
      sda      <= 1'b1;
    end else begin
      phase    <= phase_next;
      seg      <= seg_next;
      stage    <= stage_next;
      page     <= page_next;
      byte_cnt <= byte_cnt_next;
      bit_cnt  <= bit_cnt_next;
      step     <= step_next;
      shift    <= shift_next;
      scl      <= scl_next;
      sda      <= sda_next;
    end
  end

  // a refresh ends on the last stop step, with the bus released
  `PFB_ASSERT(a_end_bus_free, $fell(busy) |-> (scl && sda))
  // pins move only on a tick
  `PFB_ASSERT(a_pins_hold, !$past(ctrl.tick) |-> ($stable(scl) && $stable(sda)))
  // a start arms the sequence
  `PFB_ASSERT_NEXT(a_start_arms, ctrl.start, busy)

endmodule

`default_nettype wire

### design/page_frame_buffer_i2c_refresh_core.sv
`default_nettype none
`include "page_frame_buffer_i2c_refresh_core_macros.svh"

// Page-mode monochrome frame store with a bit-banged two-wire refresh.
// Pixel (x, y) is bit y%8 of byte x + (y/8)*COLUMNS in a synchronous store
// with separate read and write ports. The accept cycle of an item issues
// the store read, the next cycle executes the opcode (read-modify-write for
// pixels, one pin step for a tick) and loads the output register. The next
// item is accepted in the cycle after that at the earliest, and only once the
// result beat has been taken: input stalls while a result waits, so the
// block never takes a new item before it is through with the last one.
// A tick moves the bus by exactly one pin step, so a full refresh of the
// default geometry needs 38032 ticks. Reset and the clear-store opcode run
// a clearing pass over all COLUMNS*PAGES bytes (1024 at the default size),
// one byte per cycle, while input is stalled; the clear-store result beat is
// offered as that pass starts. Opcodes other than tick that arrive during a
// refresh are dropped and flagged as rejected. The device address register
// may be written only while the block is idle.
module page_frame_buffer_i2c_refresh_core #(
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = pfb_pkg::PAGES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [6:0] pixel_x,
  input  logic [5:0] pixel_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       clock_pin,
  output logic       data_pin,
  output logic       refresh_busy,
  output logic       rejected
);
  import pfb_pkg::*;

  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W  = $clog2(COLUMNS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        dev_addr;

  logic [2:0]        op_q;
  logic              pix_ok_q;
  logic [2:0]        bit_q;
  logic [ADDR_W-1:0] waddr_q;

  logic [7:0]        store [DEPTH];
  logic [7:0]        rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              accept;
  logic              exec;
  logic              is_pix_in;
  logic              is_pix_q;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] seq_addr;
  logic [7:0]        mask;

  seq_ctrl_t         seq_ctrl;
  seq_pins_t         pins_next;
  logic              seq_busy;
  logic [PAGE_W-1:0] rd_page;
  logic [COL_W-1:0]  rd_col;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign exec     = (state == ST_EXEC);

  assign is_pix_in = (opcode == OP_SET_PIXEL) || (opcode == OP_CLEAR_PIXEL);
  assign is_pix_q  = (op_q == OP_SET_PIXEL) || (op_q == OP_CLEAR_PIXEL);
  assign pix_ok    = (32'(pixel_x) < COLUMNS) && (32'(pixel_y[5:3]) < PAGES);
  assign pix_addr  = ADDR_W'(32'(pixel_x) + 32'(pixel_y[5:3]) * COLUMNS);
  assign seq_addr  = ADDR_W'(32'(rd_page) * COLUMNS + 32'(rd_col));
  assign mem_raddr = is_pix_in ? pix_addr : seq_addr;
  assign mask      = 8'h01 << bit_q;

  assign seq_ctrl.tick  = exec && (op_q == OP_TICK);
  assign seq_ctrl.start = exec && !seq_busy && (op_q == OP_REFRESH);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr_q;
    mem_wdata = rd_data | mask;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (exec && !seq_busy && is_pix_q && pix_ok_q) begin
      mem_we    = 1'b1;
      mem_wdata = (op_q == OP_SET_PIXEL) ? (rd_data | mask) : (rd_data & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data <= store[mem_raddr];
  end

  pfb_seq #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .PAGE_W  (PAGE_W),
    .COL_W   (COL_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (seq_ctrl),
    .store_byte (rd_data),
    .dev_addr   (dev_addr),
    .busy       (seq_busy),
    .rd_page    (rd_page),
    .rd_col     (rd_col),
    .pins_next  (pins_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      dev_addr  <= DEV_ADDR_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        dev_addr <= cfg_wdata;
      end
      // drop the result beat once taken
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q     <= opcode;
            pix_ok_q <= pix_ok;
            bit_q    <= pixel_y[2:0];
            waddr_q  <= pix_addr;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid    <= 1'b1;
          clock_pin    <= pins_next.scl;
          data_pin     <= pins_next.sda;
          refresh_busy <= pins_next.busy;
          rejected     <= seq_busy && (op_q != OP_TICK);
          if (!seq_busy && (op_q == OP_CLEAR_STORE)) begin
            clr_addr <= '0;
            state    <= ST_CLEAR;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // every executed item was accepted in the cycle before
  `PFB_ASSERT(a_exec_follows_accept, exec |-> $past(in_valid && !in_stall))
  // a new result beat appears only out of the execute cycle
  `PFB_ASSERT(a_result_from_exec, $rose(out_valid) |-> $past(state == ST_EXEC))
  // a rejected opcode leaves the refresh running
  `PFB_ASSERT(a_reject_busy, (out_valid && rejected) |-> refresh_busy)
  // no store write while a refresh is running
  `PFB_ASSERT(a_no_write_busy, (seq_busy && (state != ST_CLEAR)) |-> !mem_we)

endmodule

`default_nettype wire
